// ----- rtl/dbus_header_stream_parser_top_defines.svh -----
// Assertion macros shared by the checker of the header stream parser.
`ifndef DBUS_HEADER_STREAM_PARSER_TOP_DEFINES_SVH
`define DBUS_HEADER_STREAM_PARSER_TOP_DEFINES_SVH

// Checks that a property holds on every clock edge outside reset.
`define DBHSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one on the next clock edge.
`define DBHSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dbus_hsp_pkg.sv -----
// Types and constants shared by the header stream parser modules.
package dbus_hsp_pkg;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_GAP     = 4'd1,
    PH_SIGLEN  = 4'd2,
    PH_SIGCHR  = 4'd3,
    PH_SIGTERM = 4'd4,
    PH_WORD    = 4'd5,
    PH_STRCHR  = 4'd6,
    PH_STRTERM = 4'd7,
    PH_GLEN    = 4'd8,
    PH_GCHR    = 4'd9,
    PH_GTERM   = 4'd10,
    PH_PAD     = 4'd11,
    PH_BODY    = 4'd12,
    PH_HALT    = 4'd13
  } phase_t;

  localparam logic [2:0] EV_FIXED  = 3'd0;
  localparam logic [2:0] EV_STRING = 3'd1;
  localparam logic [2:0] EV_SIG    = 3'd2;
  localparam logic [2:0] EV_UINT   = 3'd3;
  localparam logic [2:0] EV_DONE   = 3'd4;
  localparam logic [2:0] EV_BODY   = 3'd5;
  localparam logic [2:0] EV_ERROR  = 3'd6;

  localparam logic [31:0] ERR_VERSION  = 32'd0;
  localparam logic [31:0] ERR_TERM     = 32'd1;
  localparam logic [31:0] ERR_SIG      = 32'd2;
  localparam logic [31:0] ERR_CROSS    = 32'd3;
  localparam logic [31:0] ERR_OVERSIZE = 32'd4;

  localparam logic [7:0] CHAR_BIG = 8'h42;
  localparam logic [7:0] CHAR_S   = 8'h73;
  localparam logic [7:0] CHAR_O   = 8'h6f;
  localparam logic [7:0] CHAR_U   = 8'h75;
  localparam logic [7:0] CHAR_G   = 8'h67;
  localparam logic [7:0] PROTO_VERSION = 8'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int TDATA_W = 160;

  typedef struct packed {
    logic [7:0]  mtype;
    logic [7:0]  mflags;
    logic        big;
    logic [31:0] body;
    logic [31:0] serial;
    logic [31:0] flen;
    logic [7:0]  field;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] val;
    logic        last;
    logic        two;
    hdr_t        hdr;
  } job_t;

endpackage

// ----- rtl/dbus_header_stream_parser_top.sv -----
// Top level of the streaming D-Bus message header parser.
//
//   Channel  Direction  tdata / tuser / tlast
//   in_      input      byte / start of message / -
//   out_     output     header values and event value / event kind / last byte
//
// The front end classifies each accepted input byte; up to four classified entries wait in
// the queue. An entry carrying two events is sent as two words, the second an EV_DONE word.
// Reset is synchronous and active low and returns the parser to the fixed header.
// Either side may stall without affecting the other until the queue fills.
module dbus_header_stream_parser_top
  import dbus_hsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,  // data_byte [7:0]
  input  logic               in_tuser,  // start_of_message [0]
  output logic               out_tvalid,
  input  logic               out_tready,
  // msg_type [7:0], msg_flags [15:8], big_endian [16], body_length [48:17],
  // serial_number [80:49], fields_length [112:81], field_code [120:113],
  // value [152:121], zero fill [159:153]
  output logic [TDATA_W-1:0] out_tdata,
  output logic [2:0]         out_tuser,  // event_res [2:0]
  output logic               out_tlast
);

  logic acc, job_valid, pop, empty, full;
  job_t job, head;

  assign in_tready = !full;
  assign acc = in_tvalid && in_tready;

  dbus_hsp_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .b(in_tdata), .som(in_tuser),
    .job_valid(job_valid), .job(job)
  );

  dbus_hsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(job_valid), .push_job(job), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  dbus_hsp_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule

// ----- rtl/dbus_hsp_front.sv -----
// Front end: parses incoming bytes and classifies the events each byte causes.
module dbus_hsp_front
  import dbus_hsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] b,
  input  logic       som,
  output logic       job_valid,
  output job_t       job
);

  phase_t      phase_r, phase_nxt, cur_ph, sw_ph;
  logic [31:0] pos_r, pos_nxt, pos;
  logic        big_r, big_nxt;
  logic [31:0] word_r, word_nxt, word_add;
  logic [1:0]  wcnt_r, wcnt_nxt;
  logic [7:0]  field_r, field_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] hend_r, hend_nxt;
  logic [31:0] body_r, body_nxt;
  logic [7:0]  mtype_r, mtype_nxt, mflags_r, mflags_nxt;
  logic [31:0] serial_r, serial_nxt, flen_r, flen_nxt;
  logic [7:0]  sigchar_r, sigchar_nxt, siglen_r, siglen_nxt;
  logic        islen_r, islen_nxt;
  logic        word_done, word_skip, hit_end, sig_suo, sig_g, in_fields;
  logic        sw_err, end_err, end_ok, size_err;
  logic [31:0] sw_code;
  logic [32:0] hl;
  logic [32:0] r8;
  logic [33:0] total;

  assign cur_ph = som ? PH_FIXED : phase_r;
  assign pos = som ? 32'd0 : pos_r;
  assign word_done = (wcnt_r == 2'd3);
  assign word_skip = (wcnt_r == 2'd0) && (pos[1:0] != 2'd0);
  assign hit_end = (({1'b0, pos} + 33'd1) == {1'b0, hend_r});
  assign sig_suo = (siglen_r == 8'd1) &&
                   (sigchar_r == CHAR_S || sigchar_r == CHAR_O || sigchar_r == CHAR_U);
  assign sig_g = (siglen_r == 8'd1) && (sigchar_r == CHAR_G);
  assign in_fields = (cur_ph != PH_FIXED) && (cur_ph != PH_PAD) &&
                     (cur_ph != PH_BODY) && (cur_ph != PH_HALT);
  assign hl = {1'b0, word_add} + 33'd16;
  assign r8 = {({1'b0, word_add[31:3]} + {29'd0, (word_add[2:0] != 3'd0)}), 3'b000};
  assign total = {1'b0, r8} + {2'b00, body_r} + 34'd16;
  assign size_err = (total[33:32] != 2'b00);

  always_comb begin
    case (wcnt_r)
      2'd0: word_add = word_r | {24'd0, b};
      2'd1: word_add = word_r | {16'd0, b, 8'd0};
      2'd2: word_add = word_r | {8'd0, b, 16'd0};
      default: word_add = word_r | {b, 24'd0};
    endcase
    if (big_r) begin
      word_add = {word_r[23:0], b};
    end
  end

  // Phase after the per-field step, before the header end check.
  always_comb begin
    sw_ph = cur_ph;
    sw_err = 1'b0;
    sw_code = ERR_TERM;
    case (cur_ph)
      PH_GAP: if (pos[2:0] == 3'd0) sw_ph = PH_SIGLEN;
      PH_SIGLEN: sw_ph = (b != 8'd0) ? PH_SIGCHR : PH_SIGTERM;
      PH_SIGCHR: if (rem_r == 32'd1) sw_ph = PH_SIGTERM;
      PH_SIGTERM: begin
        if (b != 8'd0) begin
          sw_err = 1'b1;
        end else if (sig_suo) begin
          sw_ph = PH_WORD;
        end else if (sig_g) begin
          sw_ph = PH_GLEN;
        end else begin
          sw_err = 1'b1;
          sw_code = ERR_SIG;
        end
      end
      PH_WORD: begin
        if (!word_skip && word_done) begin
          if (islen_r) sw_ph = (word_add != 32'd0) ? PH_STRCHR : PH_STRTERM;
          else sw_ph = PH_GAP;
        end
      end
      PH_STRCHR: if (rem_r == 32'd1) sw_ph = PH_STRTERM;
      PH_GCHR: if (rem_r == 32'd1) sw_ph = PH_GTERM;
      PH_GLEN: sw_ph = (b != 8'd0) ? PH_GCHR : PH_GTERM;
      PH_STRTERM, PH_GTERM: begin
        if (b != 8'd0) sw_err = 1'b1;
        else sw_ph = PH_GAP;
      end
      default: sw_ph = cur_ph;
    endcase
  end

  assign end_err = in_fields && !sw_err && hit_end && (sw_ph != PH_GAP);
  assign end_ok = in_fields && !sw_err && hit_end && (sw_ph == PH_GAP);

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; big_nxt = big_r; word_nxt = word_r;
    wcnt_nxt = wcnt_r; field_nxt = field_r; rem_nxt = rem_r; hend_nxt = hend_r;
    body_nxt = body_r; mtype_nxt = mtype_r; mflags_nxt = mflags_r;
    serial_nxt = serial_r; flen_nxt = flen_r; sigchar_nxt = sigchar_r;
    siglen_nxt = siglen_r; islen_nxt = islen_r;
    if (acc) begin
      phase_nxt = cur_ph;
      pos_nxt = pos + 32'd1;
      case (cur_ph)
        PH_HALT: pos_nxt = pos_r;
        PH_FIXED: begin
          if (pos == 32'd0) begin
            big_nxt = (b == CHAR_BIG); word_nxt = '0; wcnt_nxt = '0; field_nxt = '0;
            rem_nxt = '0; hend_nxt = '0; body_nxt = '0; mtype_nxt = '0;
            mflags_nxt = '0; serial_nxt = '0; flen_nxt = '0; sigchar_nxt = '0;
            siglen_nxt = '0; islen_nxt = 1'b0;
          end else if (pos == 32'd1) begin
            mtype_nxt = b;
          end else if (pos == 32'd2) begin
            mflags_nxt = b;
          end else if (pos == 32'd3) begin
            if (b != PROTO_VERSION) phase_nxt = PH_HALT;
          end else begin
            word_nxt = word_add;
            wcnt_nxt = wcnt_r + 2'd1;
            if (word_done) begin
              word_nxt = '0;
              if (pos == 32'd7) begin
                body_nxt = word_add;
              end else if (pos == 32'd11) begin
                serial_nxt = word_add;
              end else begin
                flen_nxt = word_add;
                if (size_err) begin
                  phase_nxt = PH_HALT;
                end else begin
                  hend_nxt = hl[31:0];
                  if (word_add != 32'd0) begin
                    phase_nxt = PH_GAP;
                  end else if (body_r != 32'd0) begin
                    phase_nxt = PH_BODY;
                    rem_nxt = body_r;
                  end else begin
                    phase_nxt = PH_FIXED;
                    pos_nxt = '0;
                  end
                end
              end
            end
          end
        end
        PH_PAD: begin
          if (pos[2:0] != 3'd7) begin
            phase_nxt = PH_PAD;
          end else if (body_r != 32'd0) begin
            phase_nxt = PH_BODY;
            rem_nxt = body_r;
          end else begin
            phase_nxt = PH_FIXED;
            pos_nxt = '0;
          end
        end
        PH_BODY: begin
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            phase_nxt = PH_FIXED;
            pos_nxt = '0;
          end
        end
        default: begin
          case (cur_ph)
            PH_GAP: if (pos[2:0] == 3'd0) field_nxt = b;
            PH_SIGLEN: begin
              siglen_nxt = b; sigchar_nxt = '0; rem_nxt = {24'd0, b};
            end
            PH_SIGCHR: begin
              if (rem_r == {24'd0, siglen_r}) sigchar_nxt = b;
              rem_nxt = rem_r - 32'd1;
            end
            PH_SIGTERM: begin
              if (sig_suo) begin
                islen_nxt = (sigchar_r != CHAR_U); word_nxt = '0; wcnt_nxt = '0;
              end
            end
            PH_WORD: begin
              if (!word_skip) begin
                word_nxt = word_add;
                wcnt_nxt = wcnt_r + 2'd1;
                if (word_done) begin
                  word_nxt = '0;
                  if (islen_r) rem_nxt = word_add;
                end
              end
            end
            PH_STRCHR, PH_GCHR: rem_nxt = rem_r - 32'd1;
            PH_GLEN: rem_nxt = {24'd0, b};
            default: rem_nxt = rem_nxt;
          endcase
          if (sw_err || end_err) begin
            phase_nxt = PH_HALT;
          end else if (end_ok) begin
            if (hend_r[2:0] != 3'd0) begin
              phase_nxt = PH_PAD;
            end else if (body_r != 32'd0) begin
              phase_nxt = PH_BODY;
              rem_nxt = body_r;
            end else begin
              phase_nxt = PH_FIXED;
              pos_nxt = '0;
            end
          end else begin
            phase_nxt = sw_ph;
          end
        end
      endcase
    end
  end

  always_comb begin
    job_valid = 1'b0;
    job.ev = EV_FIXED;
    job.val = '0;
    job.last = 1'b0;
    job.two = 1'b0;
    job.hdr = '{mtype: mtype_nxt, mflags: mflags_nxt, big: big_nxt, body: body_nxt,
                serial: serial_nxt, flen: flen_nxt, field: field_nxt};
    if (acc) begin
      case (cur_ph)
        PH_FIXED: begin
          if (pos == 32'd3 && b != PROTO_VERSION) begin
            job_valid = 1'b1; job.ev = EV_ERROR; job.val = ERR_VERSION;
          end else if (pos > 32'd3 && word_done && pos != 32'd7 && pos != 32'd11) begin
            job_valid = 1'b1;
            if (size_err) begin
              job.ev = EV_ERROR; job.val = ERR_OVERSIZE;
            end else begin
              job.two = (word_add == 32'd0);
            end
          end
        end
        PH_BODY: begin
          job_valid = 1'b1; job.ev = EV_BODY; job.val = {24'd0, b};
          job.last = (rem_r == 32'd1);
        end
        PH_HALT, PH_PAD: job_valid = 1'b0;
        default: begin
          if (sw_err) begin
            job_valid = 1'b1; job.ev = EV_ERROR; job.val = sw_code;
          end else if (end_err) begin
            job_valid = 1'b1; job.ev = EV_ERROR; job.val = ERR_CROSS;
          end else begin
            if (cur_ph == PH_WORD && !word_skip && word_done && !islen_r) begin
              job_valid = 1'b1; job.ev = EV_UINT; job.val = word_add;
            end else if (cur_ph == PH_STRCHR || cur_ph == PH_GCHR) begin
              job_valid = 1'b1;
              job.ev = (cur_ph == PH_STRCHR) ? EV_STRING : EV_SIG;
              job.val = {24'd0, b}; job.last = (rem_r == 32'd1);
            end
            if (end_ok) begin
              if (job_valid) begin
                job.two = 1'b1;
              end else begin
                job_valid = 1'b1; job.ev = EV_DONE;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED; pos_r <= '0; big_r <= 1'b0; word_r <= '0; wcnt_r <= '0;
      field_r <= '0; rem_r <= '0; hend_r <= '0; body_r <= '0; mtype_r <= '0;
      mflags_r <= '0; serial_r <= '0; flen_r <= '0; sigchar_r <= '0;
      siglen_r <= '0; islen_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; big_r <= big_nxt; word_r <= word_nxt;
      wcnt_r <= wcnt_nxt; field_r <= field_nxt; rem_r <= rem_nxt; hend_r <= hend_nxt;
      body_r <= body_nxt; mtype_r <= mtype_nxt; mflags_r <= mflags_nxt;
      serial_r <= serial_nxt; flen_r <= flen_nxt; sigchar_r <= sigchar_nxt;
      siglen_r <= siglen_nxt; islen_r <= islen_nxt;
    end
  end

endmodule

// ----- rtl/dbus_hsp_queue.sv -----
// Short queue of classified event words between the front and back ends.
module dbus_hsp_queue
  import dbus_hsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign head = mem_r[rptr_r];
  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

// ----- rtl/dbus_hsp_back.sv -----
// Back end: sends each queued entry as one or two result words.
module dbus_hsp_back
  import dbus_hsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  job_t               head,
  input  logic               empty,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);

  logic        sub_r, sub_nxt;
  logic        fire;
  logic [31:0] val;

  assign out_tvalid = !empty;
  assign fire = out_tvalid && out_tready;
  assign pop = fire && (sub_r || !head.two);
  assign out_tuser = sub_r ? EV_DONE : head.ev;
  assign val = sub_r ? 32'd0 : head.val;
  assign out_tlast = sub_r ? 1'b0 : head.last;
  assign out_tdata = {7'd0, val, head.hdr.field, head.hdr.flen, head.hdr.serial,
                      head.hdr.body, head.hdr.big, head.hdr.mflags, head.hdr.mtype};

  always_comb begin
    sub_nxt = sub_r;
    if (fire) begin
      sub_nxt = head.two && !sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

// ----- rtl/dbus_hsp_checker.sv -----
// Port checker for the header stream parser and its bind to the top level.
`include "dbus_header_stream_parser_top_defines.svh"

module dbus_hsp_checker
  import dbus_hsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [2:0]         out_tuser,
  input logic               out_tlast
);

  `DBHSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output changed while stalled")
  `DBHSP_ASSERT(a_event_range, !out_tvalid || (out_tuser != 3'd7), "event code out of range")
  `DBHSP_ASSERT(a_error_code, !(out_tvalid && out_tuser == EV_ERROR) || (out_tdata[152:121] <= ERR_OVERSIZE && !out_tlast), "bad error word")
  `DBHSP_ASSERT(a_last_kind, !(out_tvalid && out_tlast) || (out_tuser == EV_STRING || out_tuser == EV_SIG || out_tuser == EV_BODY), "last on wrong event")
  `DBHSP_ASSERT(a_full_busy, in_tready || out_tvalid, "input blocked while output idle")

endmodule

bind dbus_header_stream_parser_top dbus_hsp_checker u_dbus_hsp_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
  .out_tlast(out_tlast)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the streaming D-Bus message header parser.
`timescale 1ns / 100ps

module testbench;
  import dbus_hsp_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int K_GOOD = 0;
  localparam int K_VERSION = 1;
  localparam int K_TERM = 2;
  localparam int K_SIG = 3;
  localparam int K_CROSS = 4;
  localparam int K_OVERSIZE = 5;
  localparam int K_NOISE = 6;

  typedef struct {
    logic [2:0]  ev;
    logic [7:0]  mtype;
    logic [7:0]  mflags;
    logic        big;
    logic [31:0] body;
    logic [31:0] serial;
    logic [31:0] flen;
    logic [7:0]  field;
    logic [31:0] val;
    logic        last;
  } hdr_event_t;

  class header_scoreboard;
    hdr_event_t  pending[$];
    int          errors;
    int          checked;
    phase_t      ph;
    logic [31:0] pos;
    logic [31:0] body;
    logic [31:0] serial;
    logic [31:0] flen;
    logic [31:0] wacc;
    logic [31:0] rem;
    logic [31:0] hend;
    logic [1:0]  wcnt;
    logic        big;
    logic        is_len;
    logic [7:0]  mtype;
    logic [7:0]  mflags;
    logic [7:0]  field;
    logic [7:0]  sigc;
    logic [7:0]  sigl;
    int          step_events;

    function new();
      clear_msg();
      ph = PH_FIXED;
      pos = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void clear_msg();
      big = 0; wacc = 0; wcnt = 0; field = 0; rem = 0; hend = 0; body = 0;
      mtype = 0; mflags = 0; serial = 0; flen = 0; sigc = 0; sigl = 0; is_len = 0;
    endfunction

    function void push_event(logic [2:0] ev, logic [31:0] val, logic last);
      hdr_event_t e;
      e.ev = ev; e.mtype = mtype; e.mflags = mflags; e.big = big; e.body = body;
      e.serial = serial; e.flen = flen; e.field = field; e.val = val; e.last = last;
      pending.insert(pending.size(), e);
      step_events++;
    endfunction

    function bit add_byte(logic [7:0] b);
      if (big) wacc = {wacc[23:0], b};
      else wacc = wacc | (32'(b) << (8 * wcnt));
      wcnt = wcnt + 2'd1;
      return wcnt == 0;
    endfunction

    function bit after_header(logic [31:0] p);
      logic [63:0] body_start;
      body_start = ({32'd0, hend} + 64'd7) & ~64'd7;
      if ({32'd0, p} + 64'd1 < body_start) ph = PH_PAD;
      else if (body != 0) begin
        ph = PH_BODY;
        rem = body;
      end else return 1;
      return 0;
    endfunction

    function void note_byte(logic [7:0] b, logic som);
      logic [31:0] p;
      logic [63:0] hl;
      logic [63:0] total;
      bit restart;
      restart = 0;
      step_events = 0;
      if (som) begin
        ph = PH_FIXED;
        pos = 0;
      end
      p = pos;
      if (ph == PH_HALT) return;
      if (ph == PH_FIXED) begin
        if (p == 0) begin
          clear_msg();
          big = (b == CHAR_BIG);
        end else if (p == 1) mtype = b;
        else if (p == 2) mflags = b;
        else if (p == 3) begin
          if (b != PROTO_VERSION) begin
            ph = PH_HALT;
            push_event(EV_ERROR, ERR_VERSION, 0);
            return;
          end
        end else if (add_byte(b)) begin
          if (p == 7) body = wacc;
          else if (p == 11) serial = wacc;
          else begin
            flen = wacc;
            hl = 64'd16 + {32'd0, flen};
            total = ((hl + 64'd7) & ~64'd7) + {32'd0, body};
            if (total > 64'hFFFF_FFFF) begin
              ph = PH_HALT;
              push_event(EV_ERROR, ERR_OVERSIZE, 0);
              return;
            end
            hend = hl[31:0];
            push_event(EV_FIXED, 0, 0);
            if (flen == 0) begin
              push_event(EV_DONE, 0, 0);
              restart = after_header(p);
            end else ph = PH_GAP;
          end
          wacc = 0;
        end
        pos = restart ? 32'd0 : p + 1;
        if (restart) ph = PH_FIXED;
        return;
      end
      if (ph == PH_PAD) restart = after_header(p);
      else if (ph == PH_BODY) begin
        push_event(EV_BODY, 32'(b), rem == 1);
        rem = rem - 1;
        if (rem == 0) restart = 1;
      end else begin
        case (ph)
          PH_GAP: begin
            if (p[2:0] == 0) begin
              field = b;
              ph = PH_SIGLEN;
            end
          end
          PH_SIGLEN: begin
            sigl = b; sigc = 0; rem = 32'(b);
            ph = (b != 0) ? PH_SIGCHR : PH_SIGTERM;
          end
          PH_SIGCHR: begin
            if (rem == 32'(sigl)) sigc = b;
            rem = rem - 1;
            if (rem == 0) ph = PH_SIGTERM;
          end
          PH_SIGTERM: begin
            if (b != 0) begin
              ph = PH_HALT;
              push_event(EV_ERROR, ERR_TERM, 0);
              return;
            end
            if (sigl == 1 && (sigc == CHAR_S || sigc == CHAR_O || sigc == CHAR_U)) begin
              ph = PH_WORD;
              is_len = (sigc != CHAR_U);
              wacc = 0;
              wcnt = 0;
            end else if (sigl == 1 && sigc == CHAR_G) ph = PH_GLEN;
            else begin
              ph = PH_HALT;
              push_event(EV_ERROR, ERR_SIG, 0);
              return;
            end
          end
          PH_WORD: begin
            if (!(wcnt == 0 && p[1:0] != 0) && add_byte(b)) begin
              if (is_len) begin
                rem = wacc;
                ph = (rem != 0) ? PH_STRCHR : PH_STRTERM;
              end else begin
                push_event(EV_UINT, wacc, 0);
                ph = PH_GAP;
              end
              wacc = 0;
            end
          end
          PH_STRCHR, PH_GCHR: begin
            push_event((ph == PH_STRCHR) ? EV_STRING : EV_SIG, 32'(b), rem == 1);
            rem = rem - 1;
            if (rem == 0) ph = (ph == PH_STRCHR) ? PH_STRTERM : PH_GTERM;
          end
          PH_GLEN: begin
            rem = 32'(b);
            ph = (b != 0) ? PH_GCHR : PH_GTERM;
          end
          default: begin
            if (b != 0) begin
              ph = PH_HALT;
              push_event(EV_ERROR, ERR_TERM, 0);
              return;
            end
            ph = PH_GAP;
          end
        endcase
        if ({1'b0, p} + 33'd1 == {1'b0, hend}) begin
          if (ph != PH_GAP) begin
            // A field cut by the header end replaces anything this byte produced.
            repeat (step_events) void'(pending.pop_back());
            ph = PH_HALT;
            push_event(EV_ERROR, ERR_CROSS, 0);
            return;
          end
          push_event(EV_DONE, 0, 0);
          restart = after_header(p);
        end
      end
      if (restart) begin
        ph = PH_FIXED;
        pos = 0;
      end else pos = p + 1;
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] ev, logic [TDATA_W-1:0] d, logic last);
      hdr_event_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, event expected none actual %0d", $time, ev);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      compare("event", 32'(e.ev), 32'(ev));
      compare("msg_type", 32'(e.mtype), 32'(d[7:0]));
      compare("msg_flags", 32'(e.mflags), 32'(d[15:8]));
      compare("big_endian", 32'(e.big), 32'(d[16]));
      compare("body_length", e.body, d[48:17]);
      compare("serial_number", e.serial, d[80:49]);
      compare("fields_length", e.flen, d[112:81]);
      compare("field_code", 32'(e.field), 32'(d[120:113]));
      compare("value", e.val, d[152:121]);
      compare("last", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [TDATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  header_scoreboard sb = new();
  logic [8:0] stream[$];
  int cycles = 0;
  int bytes_sent = 0;
  int msgs_built = 0;
  int burst_left = 0;
  bit no_idle = 0;
  bit need_sync = 1;
  int stall_len = 0;
  int stall_cnt = 0;

  dbus_header_stream_parser_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("dbus_header_stream_parser_top: mismatch");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_cnt = 16 + $urandom_range(0, 24);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    stall_cnt--;
    out_tready <= (stall_cnt % 8) >= stall_len;
  end

  function automatic void put32(ref logic [7:0] m[$], input logic [31:0] w, input bit be);
    for (int i = 0; i < 4; i++) m.insert(m.size(), be ? w[8*(3-i) +: 8] : w[8*i +: 8]);
  endfunction

  function automatic void align_to(ref logic [7:0] m[$], input int n);
    while (m.size() % n != 0) m.insert(m.size(), 8'd0);
  endfunction

  function automatic void build_msg(int kind, bit be, int nfields, int slen_max, int blen);
    logic [7:0] m[$];
    logic [7:0] ftype;
    logic [31:0] fl;
    logic [31:0] bl;
    int sig_term_at;
    int n;
    bit mark;
    sig_term_at = -1;
    msgs_built++;
    if (kind == K_NOISE) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        stream.insert(stream.size(),
                      {(i == 0) || ($urandom_range(0, 7) == 0), 8'($urandom)});
      need_sync = 1;
      return;
    end
    for (int i = 0; i < 16; i++) m.insert(m.size(), 8'd0);
    if ((kind == K_TERM || kind == K_SIG || kind == K_CROSS) && nfields == 0) nfields = 1;
    for (int f = 0; f < nfields; f++) begin
      align_to(m, 8);
      case ($urandom_range(0, 3))
        0: ftype = CHAR_S;
        1: ftype = CHAR_O;
        2: ftype = CHAR_G;
        default: ftype = CHAR_U;
      endcase
      if (kind == K_SIG && f == nfields - 1) ftype = 8'($urandom);
      m.insert(m.size(), 8'($urandom));
      m.insert(m.size(), 8'd1);
      m.insert(m.size(), ftype);
      sig_term_at = m.size();
      m.insert(m.size(), 8'd0);
      n = $urandom_range(0, slen_max);
      if (ftype == CHAR_U) begin
        align_to(m, 4);
        put32(m, $urandom, be);
      end else if (ftype == CHAR_G) begin
        m.insert(m.size(), 8'(n));
        for (int i = 0; i < n; i++) m.insert(m.size(), 8'($urandom));
        m.insert(m.size(), 8'd0);
      end else if (ftype == CHAR_S || ftype == CHAR_O) begin
        align_to(m, 4);
        put32(m, n, be);
        for (int i = 0; i < n; i++) m.insert(m.size(), 8'($urandom));
        m.insert(m.size(), 8'd0);
      end
    end
    fl = m.size() - 16;
    if (kind == K_TERM) m[sig_term_at] = 8'($urandom_range(1, 255));
    if (kind == K_CROSS) fl = fl - $urandom_range(1, 3);
    bl = blen;
    if (kind == K_OVERSIZE) begin
      if ($urandom_range(0, 1)) bl = 32'hFFFF_FFFF - $urandom_range(0, 7);
      else fl = 32'hFFFF_FFFF - $urandom_range(0, 7);
    end
    m[0] = be ? CHAR_BIG : 8'h6c;
    m[1] = 8'($urandom);
    m[2] = 8'($urandom);
    m[3] = (kind == K_VERSION) ? 8'($urandom_range(2, 255)) : PROTO_VERSION;
    for (int i = 0; i < 4; i++) begin
      m[4 + i] = be ? bl[8*(3-i) +: 8] : bl[8*i +: 8];
      m[8 + i] = 8'($urandom);
      m[12 + i] = be ? fl[8*(3-i) +: 8] : fl[8*i +: 8];
    end
    if (kind == K_OVERSIZE) m = m[0:15];
    else if (kind == K_VERSION) m = m[0:$urandom_range(3, 15)];
    else if (kind == K_GOOD) begin
      align_to(m, 8);
      for (int i = 0; i < blen; i++) m.insert(m.size(), 8'($urandom));
    end
    mark = need_sync || $urandom_range(0, 1);
    foreach (m[i]) stream.insert(stream.size(), {(i == 0) && mark, m[i]});
    need_sync = (kind != K_GOOD);
  endfunction

  task automatic send_byte(logic [8:0] item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!no_idle && $urandom_range(0, 1)) begin
        gap = $urandom_range(1, 5);
        @(negedge clk);
        in_tvalid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1;
    in_tdata <= item[7:0];
    in_tuser <= item[8];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_stream();
    while (stream.size() > 0) send_byte(stream.pop_front());
  endtask

  initial begin
    int r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    build_msg(K_GOOD, 0, 0, 0, 0);
    build_msg(K_GOOD, 1, 0, 0, 3);
    build_msg(K_GOOD, 0, 4, 0, 1);
    build_msg(K_GOOD, 1, 4, 6, 5);
    build_msg(K_GOOD, 0, 3, 9, 0);
    build_msg(K_VERSION, 0, 0, 0, 0);
    build_msg(K_GOOD, 1, 2, 3, 2);
    build_msg(K_TERM, 0, 2, 3, 0);
    build_msg(K_SIG, 1, 1, 2, 0);
    build_msg(K_CROSS, 0, 2, 4, 0);
    build_msg(K_OVERSIZE, 1, 0, 0, 0);
    build_msg(K_OVERSIZE, 0, 0, 0, 0);
    build_msg(K_NOISE, 0, 0, 0, 0);
    build_msg(K_GOOD, 0, 1, 4, 4);
    flush_stream();

    while (bytes_sent < 900) begin
      r = $urandom_range(0, 19);
      no_idle = ($urandom_range(0, 3) == 0);
      if (r < 13) build_msg(K_GOOD, $urandom_range(0, 1), $urandom_range(0, 4),
                            $urandom_range(0, 12), $urandom_range(0, 20));
      else build_msg(r - 12, $urandom_range(0, 1), $urandom_range(0, 3), 6, 0);
      flush_stream();
    end

    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d bytes in %0d messages, normal and malformed, in both byte orders.",
             bytes_sent, msgs_built);
    $display("Checked %0d parser events with random source gaps and sink stalls.", sb.checked);
    if (sb.errors == 0) $display("dbus_header_stream_parser_top: match");
    else $display("dbus_header_stream_parser_top: mismatch");
    $finish;
  end
endmodule
